>>> sv/reorder_buffer_top_macros.svh
// -----------------------------------------------------------------------------
// Reorder buffer assertion macros
// Shared concurrent assertion forms for the reorder buffer checkers.
// -----------------------------------------------------------------------------
`ifndef REORDER_BUFFER_TOP_MACROS_SVH
`define REORDER_BUFFER_TOP_MACROS_SVH

// Assertion sampled on the rising clock edge and switched off while in reset.
`define ROB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Assertion that also holds while the reset is applied.
`define ROB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/rob_pkg.sv
// -----------------------------------------------------------------------------
// Reorder buffer package
// Sizes, operation and status codes, and the word types shared by the block.
// -----------------------------------------------------------------------------
package rob_pkg;

    // Number of slots in the circular buffer.
    localparam int ROB_DEPTH = 16;
    localparam int PTR_W     = $clog2(ROB_DEPTH);
    localparam int OCC_W     = $clog2(ROB_DEPTH + 1);
    localparam int TAG_W     = 4;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [OCC_W-1:0] occ_t;
    typedef logic [TAG_W-1:0] tag_t;

    // Operation selector carried with every input word.
    typedef enum logic [1:0] {
        FN_ALLOC    = 2'd0,
        FN_COMPLETE = 2'd1,
        FN_COMMIT   = 2'd2,
        FN_INSPECT  = 2'd3
    } func_t;

    // Status returned with every result word.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_BUSY  = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

    // Stage of one slot.
    typedef enum logic [1:0] {
        STG_IDLE     = 2'd0,
        STG_INFLIGHT = 2'd1,
        STG_DONE     = 2'd2
    } stage_t;

    // Contents of one slot, also the slot part of a result word.
    typedef struct packed {
        stage_t      stage;
        logic [5:0]  op;
        logic [4:0]  dest;
        logic        dest_fp;
        logic [31:0] pc;
        logic [31:0] value;
    } slot_t;

    // One input word.
    typedef struct packed {
        func_t       func;
        logic [5:0]  op_code;
        logic [4:0]  dest_reg;
        logic        dest_is_fp;
        logic [31:0] instr_pc;
        tag_t        entry_tag;
        logic [31:0] result_value;
    } item_t;

    // One result word.
    typedef struct packed {
        status_t status;
        tag_t    tag_out;
        slot_t   entry;
        logic    is_full;
        logic    is_empty;
        logic    head_is_ready;
        tag_t    head_index;
    } result_t;

    // Advance a slot pointer round the ring.
    function automatic ptr_t ptr_inc(input ptr_t p);
        return (32'(p) == ROB_DEPTH - 1) ? '0 : ptr_t'(32'(p) + 1);
    endfunction

endpackage

>>> sv/rob_in_stage.sv
// -----------------------------------------------------------------------------
// Reorder buffer input stage
// Input register that holds one word until the core takes it.
// -----------------------------------------------------------------------------
module rob_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rob_pkg::item_t in_item,
    output logic           held_valid,
    input  logic           held_take,
    output rob_pkg::item_t held_item
);
    import rob_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // A new word enters when the register is empty or being emptied.
    assign in_ready   = !valid_reg || held_take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> sv/rob_core.sv
// -----------------------------------------------------------------------------
// Reorder buffer core
// Slot storage, ring pointers and the single-pass step logic for one word.
// -----------------------------------------------------------------------------
module rob_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  rob_pkg::item_t   item,
    output rob_pkg::result_t result
);
    import rob_pkg::*;

    slot_t slot_reg  [ROB_DEPTH];
    slot_t slot_next [ROB_DEPTH];
    ptr_t  head_reg, head_next;
    ptr_t  tail_reg, tail_next;
    occ_t  occ_reg, occ_next;

    ptr_t  tag_idx;
    logic  tag_ok;
    logic  full;
    slot_t rd_slot;
    slot_t new_slot;

    assign tag_idx = ptr_t'(item.entry_tag);
    assign tag_ok  = 32'(item.entry_tag) < ROB_DEPTH;
    assign full    = 32'(occ_reg) >= ROB_DEPTH;

    // One slot read per word: the head for commit, the tag otherwise.
    assign rd_slot = (item.func == FN_COMMIT) ? slot_reg[head_reg] : slot_reg[tag_idx];

    // Step logic: next state and the result word.
    always_comb
    begin
        slot_next = slot_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        result    = '0;
        new_slot  = '0;
        case (item.func)
            FN_ALLOC:
            begin
                if (full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    new_slot.stage   = STG_INFLIGHT;
                    new_slot.op      = item.op_code;
                    new_slot.dest    = item.dest_reg;
                    new_slot.dest_fp = item.dest_is_fp;
                    new_slot.pc      = item.instr_pc;
                    new_slot.value   = 32'h0;
                    slot_next[tail_reg] = new_slot;
                    tail_next       = ptr_inc(tail_reg);
                    occ_next        = occ_reg + occ_t'(1);
                    result.tag_out  = tag_t'(tail_reg);
                    result.entry    = new_slot;
                end
            end
            FN_COMPLETE:
            begin
                result.tag_out = item.entry_tag;
                if (!tag_ok)
                begin
                    result.status = ST_NOT_BUSY;
                end
                else if (rd_slot.stage == STG_INFLIGHT)
                begin
                    new_slot        = rd_slot;
                    new_slot.stage  = STG_DONE;
                    new_slot.value  = item.result_value;
                    slot_next[tag_idx] = new_slot;
                    result.entry    = new_slot;
                end
                else
                begin
                    result.status = ST_NOT_BUSY;
                    result.entry  = rd_slot;
                end
            end
            FN_COMMIT:
            begin
                result.tag_out = tag_t'(head_reg);
                if (occ_reg != '0 && rd_slot.stage == STG_DONE)
                begin
                    result.entry        = rd_slot;
                    slot_next[head_reg] = '0;
                    head_next           = ptr_inc(head_reg);
                    occ_next            = occ_reg - occ_t'(1);
                end
                else
                begin
                    result.status = ST_NOT_READY;
                end
            end
            FN_INSPECT:
            begin
                result.tag_out = item.entry_tag;
                if (tag_ok)
                begin
                    result.entry = rd_slot;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase

        // Buffer flags as they stand after this word.
        result.is_full       = 32'(occ_next) >= ROB_DEPTH;
        result.is_empty      = occ_next == '0;
        result.head_is_ready = occ_next != '0 && slot_next[head_next].stage == STG_DONE;
        result.head_index    = tag_t'(head_next);
    end

    // State update when the word moves on to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROB_DEPTH; i++)
            begin
                slot_reg[i] <= '0;
            end
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else if (step)
        begin
            slot_reg <= slot_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

endmodule

>>> sv/rob_out_stage.sv
// -----------------------------------------------------------------------------
// Reorder buffer output stage
// Result register that holds one word until the receiver takes it.
// -----------------------------------------------------------------------------
module rob_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    output logic             load_ready,
    input  rob_pkg::result_t load_result,
    output logic             out_valid,
    input  logic             out_ready,
    output rob_pkg::result_t out_result
);
    import rob_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // The register takes a new word when empty or emptied in this cycle.
    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            result_reg <= load_result;
        end
    end

endmodule

>>> sv/reorder_buffer_top.sv
// -----------------------------------------------------------------------------
// Reorder buffer top level
// Sixteen-slot circular reorder buffer with streaming input and result ports.
// -----------------------------------------------------------------------------
// Every input word on the s_ group carries one operation in s_tuser: allocate
// at the tail, complete a slot by tag, commit the head, or inspect a slot.
// Every accepted word produces exactly one result word on the m_ group, with
// the status in m_tuser and the returned slot and buffer flags in m_tdata.
// A word is registered on entry, processed by single-pass logic that also
// updates the slot store, and written to a result register. One word is
// accepted every cycle while the result side is not stalled; the rate is
// set by the single-pass read-modify-write of the slot store.
// When the receiver holds m_tready low the result register keeps its word,
// the input register still takes one more word, and s_tready then falls
// until the result is taken. Reset empties both registers, returns every
// slot to idle with zero contents and clears the pointers and occupancy.
// -----------------------------------------------------------------------------
module reorder_buffer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // from bit 0: op_code(6), dest_reg(5),
    // dest_is_fp(1), instr_pc(32), entry_tag(4), result_value(32)
    input  logic [79:0] s_tdata,
    // func(2)
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // from bit 0: tag_out(4), entry_stage(2), entry_op(6), entry_dest(5),
    // entry_dest_fp(1), entry_pc(32), entry_value(32), is_full(1),
    // is_empty(1), head_is_ready(1), head_index(4), zero padding(7)
    output logic [95:0] m_tdata,
    // status(2)
    output logic [1:0]  m_tuser
);
    import rob_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    core_step;
    logic    load_ready;
    result_t core_result;
    result_t out_result;

    // Unpack the input word.
    always_comb
    begin
        in_item.func         = func_t'(s_tuser);
        in_item.op_code      = s_tdata[5:0];
        in_item.dest_reg     = s_tdata[10:6];
        in_item.dest_is_fp   = s_tdata[11];
        in_item.instr_pc     = s_tdata[43:12];
        in_item.entry_tag    = s_tdata[47:44];
        in_item.result_value = s_tdata[79:48];
    end

    // A held word is processed when the result register can take it.
    assign core_step = held_valid && load_ready;

    rob_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_take  (load_ready),
        .held_item  (held_item)
    );

    rob_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (core_step),
        .item   (held_item),
        .result (core_result)
    );

    rob_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (held_valid),
        .load_ready  (load_ready),
        .load_result (core_result),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    // Pack the result word.
    assign m_tuser = out_result.status;
    assign m_tdata = {7'b0,
                      out_result.head_index,
                      out_result.head_is_ready,
                      out_result.is_empty,
                      out_result.is_full,
                      out_result.entry.value,
                      out_result.entry.pc,
                      out_result.entry.dest_fp,
                      out_result.entry.dest,
                      out_result.entry.op,
                      out_result.entry.stage,
                      out_result.tag_out};

endmodule

>>> sv/rob_checker.sv
// -----------------------------------------------------------------------------
// Reorder buffer checker
// Port-level assertions on the reorder buffer, bound to the top level.
// -----------------------------------------------------------------------------
`include "reorder_buffer_top_macros.svh"

module rob_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import rob_pkg::*;

    logic stalled;
    logic refused;
    logic flag_full;
    logic flag_empty;
    logic flag_ready;

    // Views of the result channel used by the assertions.
    assign stalled    = m_tvalid && !m_tready;
    assign refused    = m_tvalid && m_tuser == ST_FULL;
    assign flag_full  = m_tdata[82];
    assign flag_empty = m_tdata[83];
    assign flag_ready = m_tdata[84];

    // A stalled result word holds still.
    `ROB_ASSERT(a_hold, stalled |=> m_tvalid && $stable({m_tuser, m_tdata}), "held word changed")

    // The input side only stalls when both registers are full and blocked.
    `ROB_ASSERT(a_stall, !s_tready |-> stalled, "input stalled without a blocked result")

    // The buffer is never full and empty at once.
    `ROB_ASSERT(a_flags, m_tvalid |-> !(flag_full && flag_empty), "full and empty together")

    // A ready head implies a non-empty buffer.
    `ROB_ASSERT(a_ready, m_tvalid && flag_ready |-> !flag_empty, "head ready while empty")

    // A refused allocation leaves the buffer full and returns tag zero.
    `ROB_ASSERT(a_full, refused |-> flag_full && m_tdata[3:0] == 4'd0, "refused while not full")

endmodule

bind reorder_buffer_top rob_checker u_rob_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/reorder_buffer_checker.sv
// -----------------------------------------------------------------------------
// Reorder buffer result checker
// Watches both stream channels of the reorder buffer. It keeps its own copy of
// the slot store and pointers, works out the result word for every accepted
// input word, and compares each returned word, field by field, with the oldest
// prediction still waiting.
// -----------------------------------------------------------------------------
module reorder_buffer_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          words_checked,
    output int          mismatches,
    output int          pending
);

    import rob_pkg::*;

    // Shadow copy of the slot store and the ring pointers.
    slot_t       rob_slots [ROB_DEPTH];
    ptr_t        head_q;
    ptr_t        tail_q;
    int unsigned occ;

    // Predicted result words, oldest first.
    result_t     predicted_q [$];
    int          checked_count;
    int          fail_count;

    // Perform one operation on the shadow state and return its result word.
    function automatic result_t apply_word(input item_t w);
        result_t     r;
        int unsigned idx;
        r   = '0;
        idx = w.entry_tag;
        case (w.func)
            FN_ALLOC:
            begin
                if (occ >= ROB_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    rob_slots[tail_q].stage   = STG_INFLIGHT;
                    rob_slots[tail_q].op      = w.op_code;
                    rob_slots[tail_q].dest    = w.dest_reg;
                    rob_slots[tail_q].dest_fp = w.dest_is_fp;
                    rob_slots[tail_q].pc      = w.instr_pc;
                    rob_slots[tail_q].value   = '0;
                    r.tag_out = tag_t'(tail_q);
                    r.entry   = rob_slots[tail_q];
                    tail_q    = ptr_t'((int'(tail_q) + 1) % ROB_DEPTH);
                    occ++;
                end
            end
            FN_COMPLETE:
            begin
                r.tag_out = w.entry_tag;
                if (idx >= ROB_DEPTH)
                    r.status = ST_NOT_BUSY;
                else
                begin
                    // Only an in-flight slot takes a result; any other is left alone.
                    if (rob_slots[idx].stage == STG_INFLIGHT)
                    begin
                        rob_slots[idx].value = w.result_value;
                        rob_slots[idx].stage = STG_DONE;
                    end
                    else
                        r.status = ST_NOT_BUSY;
                    r.entry = rob_slots[idx];
                end
            end
            FN_COMMIT:
            begin
                r.tag_out = tag_t'(head_q);
                if (occ != 0 && rob_slots[head_q].stage == STG_DONE)
                begin
                    // The slot is reported as it stood before it was cleared.
                    r.entry           = rob_slots[head_q];
                    rob_slots[head_q] = '0;
                    head_q            = ptr_t'((int'(head_q) + 1) % ROB_DEPTH);
                    occ--;
                end
                else
                    r.status = ST_NOT_READY;
            end
            default:
            begin
                r.tag_out = w.entry_tag;
                if (idx < ROB_DEPTH)
                    r.entry = rob_slots[idx];
            end
        endcase

        // Buffer flags describe the state after the operation.
        r.is_full       = (occ >= ROB_DEPTH);
        r.is_empty      = (occ == 0);
        r.head_is_ready = (occ != 0) && (rob_slots[head_q].stage == STG_DONE);
        r.head_index    = tag_t'(head_q);
        return r;
    endfunction

    // Names of the fields in which two result words differ.
    function automatic string differing_fields(input result_t want, input result_t got);
        string bad;
        bad = "";
        if (want.status        != got.status)        bad = {bad, " status"};
        if (want.tag_out       != got.tag_out)       bad = {bad, " tag_out"};
        if (want.entry.stage   != got.entry.stage)   bad = {bad, " entry_stage"};
        if (want.entry.op      != got.entry.op)      bad = {bad, " entry_op"};
        if (want.entry.dest    != got.entry.dest)    bad = {bad, " entry_dest"};
        if (want.entry.dest_fp != got.entry.dest_fp) bad = {bad, " entry_dest_fp"};
        if (want.entry.pc      != got.entry.pc)      bad = {bad, " entry_pc"};
        if (want.entry.value   != got.entry.value)   bad = {bad, " entry_value"};
        if (want.is_full       != got.is_full)       bad = {bad, " is_full"};
        if (want.is_empty      != got.is_empty)      bad = {bad, " is_empty"};
        if (want.head_is_ready != got.head_is_ready) bad = {bad, " head_is_ready"};
        if (want.head_index    != got.head_index)    bad = {bad, " head_index"};
        return bad;
    endfunction

    function automatic string result_text(input result_t r);
        return $sformatf("st=%0d tag=%0d stg=%0d op=%0d dst=%0d fp=%0d pc=%h val=%h f=%0d e=%0d r=%0d h=%0d",
                         r.status, r.tag_out, r.entry.stage, r.entry.op, r.entry.dest,
                         r.entry.dest_fp, r.entry.pc, r.entry.value, r.is_full, r.is_empty,
                         r.head_is_ready, r.head_index);
    endfunction

    // Predict on every accepted input word and check every accepted result word.
    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   w;
        result_t got;
        result_t want;
        string   bad;
        int      i;
        if (!rst_n)
        begin
            for (i = 0; i < ROB_DEPTH; i++)
                rob_slots[i] = '0;
            head_q = '0;
            tail_q = '0;
            occ    = 0;
            predicted_q.delete();
            checked_count = 0;
            fail_count    = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                w.func         = func_t'(s_tuser);
                w.op_code      = s_tdata[5:0];
                w.dest_reg     = s_tdata[10:6];
                w.dest_is_fp   = s_tdata[11];
                w.instr_pc     = s_tdata[43:12];
                w.entry_tag    = s_tdata[47:44];
                w.result_value = s_tdata[79:48];
                predicted_q.push_back(apply_word(w));
            end

            if (m_tvalid && m_tready)
            begin
                got.status        = status_t'(m_tuser);
                got.tag_out       = m_tdata[3:0];
                got.entry.stage   = stage_t'(m_tdata[5:4]);
                got.entry.op      = m_tdata[11:6];
                got.entry.dest    = m_tdata[16:12];
                got.entry.dest_fp = m_tdata[17];
                got.entry.pc      = m_tdata[49:18];
                got.entry.value   = m_tdata[81:50];
                got.is_full       = m_tdata[82];
                got.is_empty      = m_tdata[83];
                got.head_is_ready = m_tdata[84];
                got.head_index    = m_tdata[88:85];

                if (predicted_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with no prediction waiting: %s",
                                 checked_count, result_text(got));
                end
                else
                begin
                    want = predicted_q.pop_front();
                    bad  = differing_fields(want, got);
                    if (bad != "")
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("result %0d differs in%s", checked_count, bad);
                            $display("  expected %s", result_text(want));
                            $display("  actual   %s", result_text(got));
                        end
                    end
                end
                checked_count++;
            end
        end

        words_checked <= checked_count;
        mismatches    <= fail_count;
        pending       <= predicted_q.size();
    end

endmodule

>>> sim/reorder_buffer_top_tb.sv
// -----------------------------------------------------------------------------
// Reorder buffer testbench
// Drives operation words into the reorder buffer and takes its result words,
// with random gaps on both sides. A short directed run covers the reset
// contents, the empty, full, not-in-flight and head-not-ready cases and the
// field extremes; random runs then fill and drain the ring in random segments. The
// checker beside the block predicts and compares; this module gives the verdict.
// -----------------------------------------------------------------------------
module reorder_buffer_top_tb;

    import rob_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = FN_ALLOC;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    int words_sent = 0;
    int words_checked;
    int mismatches;
    int pending;

    // Idling style of each side: 0 none, 1 uniform gaps, 2 occasional gaps.
    int src_mode  = 2;
    int sink_mode = 0;

    always #4 clk = ~clk;

    reorder_buffer_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    reorder_buffer_checker rob_watch
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .words_checked (words_checked),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    function automatic int draw_gap(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 15);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    // Offer one word and hold it until the block takes it. Valid is only
    // lowered when a gap follows, so back-to-back words keep it high.
    task automatic issue(input func_t f, input logic [5:0] op, input logic [4:0] dest,
                         input logic fp, input logic [31:0] pc, input tag_t tag,
                         input logic [31:0] val);
        int gap;
        gap = draw_gap(src_mode);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {val, tag, pc, fp, dest, op};
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    // Result side: random stalls, and one long hold-off that backs the block up.
    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (rst_n);
        forever
        begin
            stall = (taken == 300) ? 80 : draw_gap(sink_mode);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
            if (taken % 50 == 0)
                sink_mode = $urandom_range(0, 2);
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int    i;
        int    k;
        int    roll;
        int    profile;
        int    alloc_lim;
        int    done_lim;
        int    commit_lim;
        tag_t  seq_tag;
        tag_t  tag;
        func_t f;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset contents, commit on an empty ring, complete of an idle slot.
        issue(FN_INSPECT, 6'd0, 5'd0, 1'b0, 32'h0, 4'd0, 32'h0);
        issue(FN_COMMIT, 6'd0, 5'd0, 1'b0, 32'h0, 4'd0, 32'h0);
        issue(FN_COMPLETE, 6'd0, 5'd0, 1'b0, 32'h0, 4'd5, 32'h1234_5678);

        // Fill every slot with alternating extreme contents, then one more.
        for (i = 0; i < ROB_DEPTH; i++)
        begin
            if (i % 2 == 0)
                issue(FN_ALLOC, 6'h3f, 5'h1f, 1'b1, 32'hffff_ffff, 4'hf, 32'hffff_ffff);
            else
                issue(FN_ALLOC, 6'h00, 5'h00, 1'b0, 32'h0, 4'h0, 32'h0);
        end
        issue(FN_ALLOC, 6'h2a, 5'h15, 1'b1, 32'hdead_beef, 4'd0, 32'h0);

        // Complete the head twice, retire it, then find the next head not ready.
        issue(FN_COMPLETE, 6'd0, 5'd0, 1'b0, 32'h0, 4'd0, 32'hffff_ffff);
        issue(FN_COMPLETE, 6'd0, 5'd0, 1'b0, 32'h0, 4'd0, 32'h0);
        issue(FN_COMMIT, 6'd0, 5'd0, 1'b0, 32'h0, 4'd0, 32'h0);
        issue(FN_COMMIT, 6'd0, 5'd0, 1'b0, 32'h0, 4'd0, 32'h0);
        issue(FN_INSPECT, 6'd0, 5'd0, 1'b0, 32'h0, 4'hf, 32'h0);

        // Random runs in segments that lean towards filling, draining or neither.
        seq_tag = '0;
        profile = 2;
        for (k = 0; k < 1075; k++)
        begin
            if (k % 40 == 0)
            begin
                profile  = $urandom_range(0, 2);
                src_mode = $urandom_range(0, 2);
            end

            // Let the block run dry once in the middle.
            if (k == 500)
            begin
                s_tvalid <= 1'b0;
                wait (words_checked >= words_sent);
            end

            case (profile)
                0:
                begin
                    alloc_lim  = 50;
                    done_lim   = 75;
                    commit_lim = 90;
                end
                1:
                begin
                    alloc_lim  = 10;
                    done_lim   = 50;
                    commit_lim = 90;
                end
                default:
                begin
                    alloc_lim  = 30;
                    done_lim   = 60;
                    commit_lim = 90;
                end
            endcase

            roll = $urandom_range(0, 99);
            if (roll < alloc_lim)
                f = FN_ALLOC;
            else if (roll < done_lim)
                f = FN_COMPLETE;
            else if (roll < commit_lim)
                f = FN_COMMIT;
            else
                f = FN_INSPECT;

            // While draining, completions sweep the ring so that the head is soon done.
            if (profile == 1 && f == FN_COMPLETE)
            begin
                tag     = seq_tag;
                seq_tag = seq_tag + 1'b1;
            end
            else
                tag = tag_t'($urandom);

            issue(f, 6'($urandom), 5'($urandom), 1'($urandom), $urandom, tag, $urandom);
        end
        s_tvalid <= 1'b0;

        wait (words_checked >= words_sent);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin : watchdog
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
